// ----- src/nrle_pkg.sv -----
// ----------------------------------------------------------------------------
// nrle_pkg: shared types and constants of the nibble RLE tile decoder
// Holds widths, the controller state type and the command/status structs.
// ----------------------------------------------------------------------------
package nrle_pkg;

  localparam int unsigned MaxCharsDef    = 2048;
  localparam int unsigned WordW          = 32;
  localparam int unsigned CfgW           = 12;
  localparam int unsigned CountW         = 14;
  localparam int unsigned NibW           = 4;
  localparam int unsigned NibblesPerWord = 8;
  localparam int unsigned RunW           = 5;  // run length 1..16
  localparam int unsigned TakeW          = 4;  // nibbles per step 1..8
  localparam int unsigned NibLeftW       = 7;  // nibbles per word 4..64

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } nrle_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // take the input request
    logic step;  // insert one run segment
  } nrle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;       // request yields no results
    logic word_done;  // current step finishes the word
    logic out_free;   // output register can take a result
  } nrle_status_t;

endpackage

// ----- src/nrle_ifs.sv -----
// ----------------------------------------------------------------------------
// nrle_ifs: stream channels of the nibble RLE tile decoder
// Input channel carries compressed words, output channel packed pixel words.
// ----------------------------------------------------------------------------
interface nrle_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] compressed_word;
  logic        start_new;

  modport source (output valid, output compressed_word, output start_new, input ready);
  modport sink   (input valid, input compressed_word, input start_new, output ready);
endinterface

interface nrle_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        last_of_run;
  logic        limit_reached;

  modport source (output valid, output pixel_word, output last_of_run,
                  output limit_reached, input ready);
  modport sink   (input valid, input pixel_word, input last_of_run,
                  input limit_reached, output ready);
endinterface

// ----- src/nibble_rle_tile_decoder.sv -----
// ----------------------------------------------------------------------------
// nibble_rle_tile_decoder: run-length decoder of 4-bit pixel nibbles
// A word is accepted only when idle; a result shows in the cycle after the step that fills it.
// Each word is stepped once per run segment (1..12 segments): 4, plus one per run split
//   by a full accumulator, fewer when the limit ends the word; back-pressure stalls steps.
// A word that yields no result (halted or limit already met) never leaves the idle state.
// Reset clears accumulator, counts and halt; char_count resets to 1.
// ----------------------------------------------------------------------------
module nibble_rle_tile_decoder
  import nrle_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxCharsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  nrle_in_if.sink         in_i,
  nrle_out_if.source      out_o
);

  nrle_cmd_t    cmd;
  nrle_status_t status;

  // Sequence requests
  nrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Decode runs into packed words
  nrle_datapath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .compressed_word_i (in_i.compressed_word),
    .start_new_i       (in_i.start_new),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .pixel_word_o      (out_o.pixel_word),
    .last_of_run_o     (out_o.last_of_run),
    .limit_reached_o   (out_o.limit_reached)
  );

endmodule

// ----- src/nrle_ctrl.sv -----
// ----------------------------------------------------------------------------
// nrle_ctrl: sequencing controller
// Accepts one request at a time and steps the datapath until the word is done.
// ----------------------------------------------------------------------------
module nrle_ctrl
  import nrle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  nrle_status_t status_i,
  output nrle_cmd_t    cmd_o
);

  nrle_state_e state_q, state_d;

  // Hold the current state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance on accepting a request that yields results, or on the final step of a word
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !status_i.skip) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.out_free && status_i.word_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive handshake and commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/nrle_datapath.sv -----
// ----------------------------------------------------------------------------
// nrle_datapath: run insertion, accumulator, limit tracking, output register
// Each step inserts as many nibbles of the current run as fit the accumulator.
// ----------------------------------------------------------------------------
module nrle_datapath
  import nrle_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxCharsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic [WordW-1:0]  compressed_word_i,
  input  logic              start_new_i,
  input  nrle_cmd_t         cmd_i,
  output nrle_status_t      status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [WordW-1:0]  pixel_word_o,
  output logic              last_of_run_o,
  output logic              limit_reached_o
);

  logic [CfgW-1:0]     char_count_q;
  logic [WordW-1:0]    word_q;
  logic [RunW-1:0]     run_left_q;
  logic [NibLeftW-1:0] nib_left_q;
  logic [WordW-1:0]    acc_q;
  logic [2:0]          fill_q;
  logic [CountW-1:0]   emitted_q;
  logic                halted_q;
  logic                out_valid_q;
  logic [WordW-1:0]    pixel_q;
  logic                last_q;
  logic                limit_q;

  logic [CfgW-1:0]     lim_chars;
  logic [CountW-1:0]   limit;
  logic                eff_halted;
  logic [CountW-1:0]   eff_emitted;
  logic                skip;
  logic [NibLeftW-1:0] nib_total;
  logic [NibW-1:0]     data;
  logic [TakeW-1:0]    space;
  logic [TakeW-1:0]    take;
  logic [5:0]          shamt;
  logic [2*WordW-1:0]  acc_wide;
  logic [WordW:0]      mask_wide;
  logic [WordW-1:0]    acc_new;
  logic [TakeW-1:0]    fill_sum;
  logic                emit;
  logic [CountW-1:0]   emitted_inc;
  logic                lim_hit;
  logic [NibLeftW-1:0] nib_after;
  logic [RunW-1:0]     run_after;

  // Saturate the char count and scale to a word limit
  always_comb begin
    lim_chars = (char_count_q > CfgW'(MAX_CHARS)) ? CfgW'(MAX_CHARS) : char_count_q;
    limit     = {lim_chars, 2'b00};
  end

  // Evaluate the incoming request after an optional restart
  always_comb begin
    eff_halted  = start_new_i ? 1'b0 : halted_q;
    eff_emitted = start_new_i ? '0 : emitted_q;
    skip        = eff_halted || (eff_emitted >= limit);
    nib_total   = NibLeftW'(compressed_word_i[31:28]) + NibLeftW'(compressed_word_i[23:20])
                + NibLeftW'(compressed_word_i[15:12]) + NibLeftW'(compressed_word_i[7:4])
                + NibLeftW'(4);
  end

  // Insert one run segment: as many nibbles as fit or as the run has left
  always_comb begin
    data        = word_q[27:24];
    space       = TakeW'(NibblesPerWord) - {1'b0, fill_q};
    take        = (run_left_q < {1'b0, space}) ? run_left_q[TakeW-1:0] : space;
    shamt       = {take, 2'b00};
    acc_wide    = {{WordW{1'b0}}, acc_q} << shamt;
    mask_wide   = ((WordW+1)'(1) << shamt) - (WordW+1)'(1);
    acc_new     = acc_wide[WordW-1:0] | ({NibblesPerWord{data}} & mask_wide[WordW-1:0]);
    fill_sum    = {1'b0, fill_q} + take;
    emit        = (fill_sum == TakeW'(NibblesPerWord));
    emitted_inc = emitted_q + CountW'(1);
    lim_hit     = emit && (emitted_inc >= limit);
    nib_after   = nib_left_q - NibLeftW'(take);
    run_after   = run_left_q - RunW'(take);
  end

  assign status_o.skip      = skip;
  assign status_o.word_done = lim_hit || (nib_after == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      char_count_q <= cfg_wdata_i;
    end
  end

  // Decoder state: load on accept, advance on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q     <= '0;
      run_left_q <= '0;
      nib_left_q <= '0;
      acc_q      <= '0;
      fill_q     <= '0;
      emitted_q  <= '0;
      halted_q   <= 1'b0;
    end else if (cmd_i.load) begin
      word_q     <= compressed_word_i;
      run_left_q <= RunW'(compressed_word_i[31:28]) + RunW'(1);
      nib_left_q <= nib_total;
      halted_q   <= skip;
      emitted_q  <= eff_emitted;
      if (start_new_i) begin
        acc_q  <= '0;
        fill_q <= '0;
      end
    end else if (cmd_i.step) begin
      nib_left_q <= nib_after;
      if (emit) begin
        acc_q     <= '0;
        fill_q    <= '0;
        emitted_q <= emitted_inc;
      end else begin
        acc_q  <= acc_new;
        fill_q <= fill_sum[2:0];
      end
      if (lim_hit) begin
        halted_q <= 1'b1;
      end
      if (run_after == '0) begin
        word_q     <= {word_q[WordW-9:0], 8'h00};
        run_left_q <= RunW'(word_q[23:20]) + RunW'(1);
      end else begin
        run_left_q <= run_after;
      end
    end
  end

  // Output register valid: set on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && emit) begin
      pixel_q <= acc_new;
      last_q  <= lim_hit || (nib_after < NibLeftW'(NibblesPerWord));
      limit_q <= lim_hit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_word_o    = pixel_q;
  assign last_of_run_o   = last_q;
  assign limit_reached_o = limit_q;

endmodule

// ----- src/nrle_checker.sv -----
// ----------------------------------------------------------------------------
// nrle_checker: port-level assertions of the nibble RLE tile decoder
// Checks output handshake and limit signaling; bound to the top level.
// ----------------------------------------------------------------------------
module nrle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] pixel_word_i,
  input logic        last_of_run_i,
  input logic        limit_reached_i
);

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pixel_word_i) && $stable(last_of_run_i)
      && $stable(limit_reached_i))
    else $error("stalled result changed");

  // Limit result always closes its word
  a_limit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && limit_reached_i |-> last_of_run_i)
    else $error("limit result without last flag");

  // A shown result carries known values
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown({pixel_word_i, last_of_run_i, limit_reached_i}))
    else $error("result with unknown bits");

endmodule

bind nibble_rle_tile_decoder nrle_checker u_nrle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .pixel_word_i    (out_o.pixel_word),
  .last_of_run_i   (out_o.last_of_run),
  .limit_reached_i (out_o.limit_reached)
);
